// ===== hw/rtl/rotag_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rotag_pkg
// Shared types and constants of the rotation address generator.
// ----------------------------------------------------------------------------
package rotag_pkg;

	localparam int DIM_W      = 14;
	localparam int STRIDE_W   = 16;
	localparam int CHAN_W     = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int SRC_OFS_W  = 29;
	localparam int DST_OFS_W  = 28;

	localparam logic [CHAN_W-1:0] CHANNELS_RGBA = 4'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROTATION   = 3'd0,
		REG_SRC_WIDTH  = 3'd1,
		REG_SRC_HEIGHT = 3'd2,
		REG_ROW_BYTES  = 3'd3,
		REG_CHANNELS   = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ANG_0   = 2'd0,
		ANG_90  = 2'd1,
		ANG_180 = 2'd2,
		ANG_270 = 2'd3
	} angle_t;

	typedef enum logic [1:0] {
		STATUS_OK           = 2'd0,
		STATUS_BAD_ANGLE    = 2'd1,
		STATUS_BAD_CHANNELS = 2'd2,
		STATUS_BAD_SIZE     = 2'd3
	} status_t;

	typedef struct packed {
		logic [DIM_W-1:0]    src_width;
		logic [DIM_W-1:0]    src_height;
		logic [STRIDE_W-1:0] row_bytes;
		logic [CHAN_W-1:0]   channel_count;
	} cfg_t;

	typedef struct packed {
		logic   ok;
		angle_t code;
	} rot_t;

	typedef struct packed {
		logic [SRC_OFS_W-1:0] src;
		logic [DST_OFS_W-1:0] dst;
		logic [STRIDE_W-1:0]  stride;
		logic                 last;
	} pix_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rotag_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rotag_cfg
// Configuration registers and the registered reduction of the rotation
// angle to a quarter-turn code with a validity flag.
// ----------------------------------------------------------------------------
module rotag_cfg import rotag_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg,
	output rot_t                  rot,
	output logic                  settle
);

	// 2^12 is 1 modulo 45, so 12-bit chunks of the angle add up modulo 45.
	localparam logic [10:0] MOD45_RECIP    = 11'd1456;
	localparam logic [6:0]  MOD45          = 7'd45;
	// A negative angle reads as itself plus 2^32, which is 256 modulo 360
	// and 31 modulo 45.
	localparam logic [5:0]  NEG_WRAP_MOD45 = 6'd31;

	logic [31:0]         rot_deg_q;
	logic [DIM_W-1:0]    width_q;
	logic [DIM_W-1:0]    height_q;
	logic [STRIDE_W-1:0] row_bytes_q;
	logic [CHAN_W-1:0]   chan_q;
	rot_t                rot_q;
	logic                settle_q;

	logic [13:0] chunk_sum;
	logic [12:0] fold;
	logic [23:0] recip_prod;
	logic [7:0]  quot;
	logic [12:0] quot_x45;
	logic [6:0]  rem_wide;
	logic [5:0]  rem45;
	logic [5:0]  rem_target;
	rot_t        rot_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_deg_q   <= 32'd360;
			width_q     <= 14'd1;
			height_q    <= 14'd1;
			row_bytes_q <= 16'd4;
			chan_q      <= CHANNELS_RGBA;
			settle_q    <= 1'b0;
		end else begin
			settle_q <= cfg_write_en && (cfg_index == REG_ROTATION);
			if (cfg_write_en) begin
				unique case (cfg_index)
					REG_ROTATION:   rot_deg_q   <= cfg_data;
					REG_SRC_WIDTH:  width_q     <= cfg_data[DIM_W-1:0];
					REG_SRC_HEIGHT: height_q    <= cfg_data[DIM_W-1:0];
					REG_ROW_BYTES:  row_bytes_q <= cfg_data[STRIDE_W-1:0];
					REG_CHANNELS:   chan_q      <= cfg_data[CHAN_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		chunk_sum  = 14'(rot_deg_q[11:0]) + 14'(rot_deg_q[23:12]) + 14'(rot_deg_q[31:24]);
		fold       = 13'(chunk_sum[11:0]) + 13'(chunk_sum[13:12]);
		// The reciprocal is rounded down, so the quotient is short by at most one.
		recip_prod = 24'(fold) * 24'(MOD45_RECIP);
		quot       = recip_prod[23:16];
		quot_x45   = 13'(quot) * 13'(MOD45);
		rem_wide   = 7'(fold - quot_x45);
		rem45      = (rem_wide >= MOD45) ? 6'(rem_wide - MOD45) : rem_wide[5:0];
		rem_target = rot_deg_q[31] ? NEG_WRAP_MOD45 : 6'd0;
		// Divisible by 90 means zero modulo 45 and even; the quarter turn then
		// sits in bits 2:1, since 360 is a multiple of 8.
		rot_next.ok   = (rem45 == rem_target) && !rot_deg_q[0];
		rot_next.code = angle_t'(rot_deg_q[2:1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q.ok   <= 1'b1;
			rot_q.code <= ANG_0;
		end else begin
			rot_q <= rot_next;
		end
	end

	assign cfg.src_width     = width_q;
	assign cfg.src_height    = height_q;
	assign cfg.row_bytes     = row_bytes_q;
	assign cfg.channel_count = chan_q;
	assign rot               = rot_q;
	assign settle            = settle_q;

endmodule
`default_nettype wire

// ===== hw/rtl/rotag_addr.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rotag_addr
// Maps one output pixel to its source pixel and forms the source and
// destination byte offsets, the output stride and the last-pixel flag.
// ----------------------------------------------------------------------------
module rotag_addr import rotag_pkg::*; (
	input  logic [DIM_W-1:0] x,
	input  logic [DIM_W-1:0] y,
	input  angle_t           code,
	input  cfg_t             cfg,
	input  logic [DIM_W-1:0] out_w,
	input  logic [DIM_W-1:0] out_h,
	output pix_t             pix
);

	// Source coordinates can go negative when sizes change mid-frame; the
	// offsets then wrap exactly as a two's complement product does.
	logic signed [DIM_W:0]  x_s;
	logic signed [DIM_W:0]  y_s;
	logic signed [DIM_W:0]  w_m1_x;
	logic signed [DIM_W:0]  w_m1_y;
	logic signed [DIM_W:0]  h_m1_x;
	logic signed [DIM_W:0]  h_m1_y;
	logic signed [DIM_W:0]  sx;
	logic signed [DIM_W:0]  sy;
	logic signed [31:0]     row_part;
	logic signed [31:0]     col_part;
	logic signed [31:0]     src_sum;
	logic [2*DIM_W:0]       dst_pixels;

	always_comb begin
		x_s    = $signed({1'b0, x});
		y_s    = $signed({1'b0, y});
		w_m1_x = $signed({1'b0, cfg.src_width}) - x_s - 15'sd1;
		w_m1_y = $signed({1'b0, cfg.src_width}) - y_s - 15'sd1;
		h_m1_x = $signed({1'b0, cfg.src_height}) - x_s - 15'sd1;
		h_m1_y = $signed({1'b0, cfg.src_height}) - y_s - 15'sd1;

		case (code)
			ANG_0: begin
				sx = x_s;
				sy = y_s;
			end
			ANG_90: begin
				sx = y_s;
				sy = h_m1_x;
			end
			ANG_180: begin
				sx = w_m1_x;
				sy = h_m1_y;
			end
			ANG_270: begin
				sx = w_m1_y;
				sy = x_s;
			end
		endcase

		row_part = {{(32-DIM_W-1){sy[DIM_W]}}, sy} * $signed({16'd0, cfg.row_bytes});
		col_part = {{(32-DIM_W-3){sx[DIM_W]}}, sx, 2'b00};
		src_sum  = row_part + col_part;

		dst_pixels = (2*DIM_W+1)'(y) * (2*DIM_W+1)'(out_w) + (2*DIM_W+1)'(x);

		pix.src    = src_sum[SRC_OFS_W-1:0];
		pix.dst    = {dst_pixels[DST_OFS_W-3:0], 2'b00};
		pix.stride = {out_w, 2'b00};
		pix.last   = (({1'b0, x} + 15'd1) >= {1'b0, out_w}) &&
		             (({1'b0, y} + 15'd1) >= {1'b0, out_h});
	end

endmodule
`default_nettype wire

// ===== hw/rtl/image_rotation_address_generator_core.sv =====
// An accepted request waits in the input register until it may go, then its result
// is registered. Throughput: one request per cycle while results are taken; processing
// pauses after each rotation register write while the registered angle reduction settles.
// Reset (arst_n low, asynchronous): no frame running, no result pending, raster
// at pixel zero, configuration back to 360 degrees, 1 x 1 pixels, 4-byte rows, 4 channels.
`default_nettype none
// ----------------------------------------------------------------------------
// image_rotation_address_generator_core
// Steps the output raster of a rotated RGBA frame and gives the source and
// destination byte offsets of one pixel per request while a frame runs.
// ----------------------------------------------------------------------------
module image_rotation_address_generator_core import rotag_pkg::*; #(
	parameter int unsigned     MAX_DIM         = 8192,
	parameter longint unsigned MAX_FRAME_BYTES = 268435456
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  begin_frame,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [SRC_OFS_W-1:0]  src_byte_offset,
	output logic [DST_OFS_W-1:0]  dst_byte_offset,
	output logic [STRIDE_W-1:0]   out_row_bytes,
	output logic [1:0]            status_code,
	output logic                  last_pixel
);

	localparam logic [16:0] DIM_LIMIT   = 17'(MAX_DIM);
	localparam logic [31:0] FRAME_LIMIT = 32'(MAX_FRAME_BYTES);

	cfg_t cfg;
	rot_t rot;
	logic settle;

	logic             valid_s1;
	logic             begin_s1;
	logic             running_q;
	angle_t           angle_q;
	logic [DIM_W-1:0] col_q;
	logic [DIM_W-1:0] row_q;

	logic                 out_valid_q;
	logic [SRC_OFS_W-1:0] src_q;
	logic [DST_OFS_W-1:0] dst_q;
	logic [STRIDE_W-1:0]  stride_q;
	status_t              status_q;
	logic                 last_q;

	logic             out_free;
	logic             go;
	logic             produce;
	angle_t           code_use;
	logic             swap;
	logic [DIM_W-1:0] out_w;
	logic [DIM_W-1:0] out_h;
	logic [DIM_W:0]   col_inc;
	logic             col_wrap;
	logic [DIM_W:0]   row_inc;
	logic [DIM_W-1:0] next_col;
	logic [DIM_W-1:0] next_row;
	logic [DIM_W-1:0] x;
	logic [DIM_W-1:0] y;
	logic [29:0]      frame_bytes;
	logic             size_bad;
	status_t          begin_status;
	status_t          res_status;
	logic             err;
	pix_t             pix;

	rotag_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cfg          (cfg),
		.rot          (rot),
		.settle       (settle)
	);

	assign out_free = !out_valid_q || out_ready;
	assign go       = valid_s1 && !settle && out_free;
	assign in_ready = !valid_s1 || go;
	assign produce  = go && (begin_s1 || running_q);

	always_comb begin
		code_use = begin_s1 ? rot.code : angle_q;
		swap     = (code_use == ANG_90) || (code_use == ANG_270);
		out_w    = swap ? cfg.src_height : cfg.src_width;
		out_h    = swap ? cfg.src_width : cfg.src_height;

		// Compares are greater-or-equal so a frame still ends when sizes shrink.
		col_inc  = {1'b0, col_q} + 15'd1;
		col_wrap = col_inc >= {1'b0, out_w};
		next_col = col_wrap ? '0 : col_inc[DIM_W-1:0];
		row_inc  = col_wrap ? ({1'b0, row_q} + 15'd1) : {1'b0, row_q};
		if (row_inc >= {1'b0, out_h}) begin
			next_row = (out_h == '0) ? '0 : out_h - 14'd1;
		end else begin
			next_row = row_inc[DIM_W-1:0];
		end

		x = begin_s1 ? '0 : next_col;
		y = begin_s1 ? '0 : next_row;

		frame_bytes = 30'({out_w, 2'b00}) * 30'(out_h);
		size_bad    = (out_w == '0) || (out_h == '0) ||
		              (17'(out_w) > DIM_LIMIT) || (17'(out_h) > DIM_LIMIT) ||
		              (32'(frame_bytes) > FRAME_LIMIT);

		if (!rot.ok) begin
			begin_status = STATUS_BAD_ANGLE;
		end else if (cfg.channel_count != CHANNELS_RGBA) begin
			begin_status = STATUS_BAD_CHANNELS;
		end else if (size_bad) begin
			begin_status = STATUS_BAD_SIZE;
		end else begin
			begin_status = STATUS_OK;
		end
		res_status = begin_s1 ? begin_status : STATUS_OK;
		err        = res_status != STATUS_OK;
	end

	rotag_addr u_addr (
		.x     (x),
		.y     (y),
		.code  (code_use),
		.cfg   (cfg),
		.out_w (out_w),
		.out_h (out_h),
		.pix   (pix)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			begin_s1    <= 1'b0;
			running_q   <= 1'b0;
			angle_q     <= ANG_0;
			col_q       <= '0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
				begin_s1 <= begin_frame;
			end
			if (go && begin_s1 && rot.ok) begin
				angle_q <= rot.code;
			end
			if (produce) begin
				if (err) begin
					running_q <= 1'b0;
				end else begin
					col_q     <= x;
					row_q     <= y;
					running_q <= !pix.last;
				end
			end
			if (produce) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			src_q    <= err ? '0 : pix.src;
			dst_q    <= err ? '0 : pix.dst;
			stride_q <= err ? '0 : pix.stride;
			status_q <= res_status;
			last_q   <= err ? 1'b1 : pix.last;
		end
	end

	assign out_valid       = out_valid_q;
	assign src_byte_offset = src_q;
	assign dst_byte_offset = dst_q;
	assign out_row_bytes   = stride_q;
	assign status_code     = status_q;
	assign last_pixel      = last_q;

`ifndef SYNTHESIS
	a_error_result_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q != STATUS_OK) |->
			last_q && (src_q == '0) && (dst_q == '0) && (stride_q == '0))
		else $error("error result carries offsets or lacks the last mark");

	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		produce && !err && pix.last |=> !running_q)
		else $error("frame still running after its last pixel");

	a_idle_advance_silent: assert property (@(posedge clk) disable iff (!arst_n)
		go && !begin_s1 && !running_q |=> !out_valid_q)
		else $error("advance request while idle produced a result");

	a_angle_latched: assert property (@(posedge clk) disable iff (!arst_n)
		go && begin_s1 && rot.ok |=> angle_q == $past(rot.code))
		else $error("quarter-turn code not latched at frame start");
`endif

endmodule
`default_nettype wire
